// File: design/nested_region_profiler_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef NESTED_REGION_PROFILER_UNIT_DEFINES_SVH
`define NESTED_REGION_PROFILER_UNIT_DEFINES_SVH

// Property checked on every clock edge, including during reset.
`define NRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// Property checked only while out of reset.
`define NRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// File: design/nrp_pkg.sv
package nrp_pkg;

  localparam int SLOT_W   = 7;
  localparam int MODE_W   = 3;
  localparam int TS_W     = 64;
  localparam int HIT_W    = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_BEGIN = 3'd0,
    MODE_END   = 3'd1,
    MODE_START = 3'd2,
    MODE_STOP  = 3'd3,
    MODE_READ  = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NOT_STARTED = 2'd1,
    ST_RUNNING     = 2'd2
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [TS_W-1:0]   timestamp;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   read_slot;
    logic [HIT_W-1:0]    hit_count;
    logic [TS_W-1:0]     inclusive_time;
    logic [TS_W-1:0]     exclusive_time;
    logic [TS_W-1:0]     total_time;
    logic                used;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // One slot's statistics, children sum excluded (kept in its own memory).
  typedef struct packed {
    logic [TS_W-1:0]   begin_stamp;
    logic [HIT_W-1:0]  hits;
    logic [TS_W-1:0]   inclusive_sum;
    logic [SLOT_W-1:0] parent;
  } slot_rec_t;

endpackage

// File: design/nrp_stream_if.sv
interface nrp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/nested_region_profiler_unit.sv
// Nested region profiler.
// in_i carries events (mode, slot, timestamp): begin region, end region, start
// profile, stop profile, read slot. out_o carries one result per read.
// Per-slot statistics live in two single-port synchronous memories: one holds
// begin stamp, hit count, inclusive sum and parent; the other the children sum.
// Events are handled one at a time, in these steps:
//   start/stop/unused mode/out-of-range begin or end: taken in idle
//   begin: read slot, write slot
//   end:   read slot, read parent's children sum, write both
//   read:  read slot, then load the output register, plus any wait for it to drain
// The end-event sequence through both memories sets the rate.
// After reset a clearing pass zeroes both memories, one entry per cycle;
// in_i.ready stays low meanwhile. A result waits in the output register
// while out_o.ready is low; events that produce no result keep flowing,
// and a second read holds in its last step until the register is free.
module nested_region_profiler_unit #(
  parameter int SLOT_COUNT = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nrp_stream_if.sink   in_i,
  nrp_stream_if.source out_o
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOKUP = 3'd2;
  localparam logic [2:0] S_CHILD  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_q, state_d;

  // captured event
  logic [nrp_pkg::MODE_W-1:0] mode_q;
  logic [nrp_pkg::SLOT_W-1:0] slot_q;
  logic [nrp_pkg::TS_W-1:0]   ts_q;
  logic [IDX_W-1:0]           idx_q;
  logic                       slot_ok_q;
  logic [nrp_pkg::TS_W-1:0]   elapsed_q, elapsed_d;
  logic [IDX_W-1:0]           par_idx_q, par_idx_d;

  logic [nrp_pkg::SLOT_W-1:0] current_q, current_d;
  logic                       started_q, started_d;
  logic                       stopped_q, stopped_d;
  logic [nrp_pkg::TS_W-1:0]   start_ts_q, start_ts_d;
  logic [nrp_pkg::TS_W-1:0]   stop_ts_q, stop_ts_d;
  logic [IDX_W-1:0]           clr_q, clr_d;

  logic                       out_valid_q, out_valid_d;
  nrp_pkg::out_item_t         out_q, out_d;

  // memories
  nrp_pkg::slot_rec_t         rec_mem [SLOT_COUNT];
  logic [nrp_pkg::TS_W-1:0]   child_mem [SLOT_COUNT];
  nrp_pkg::slot_rec_t         rec_rd_q, rec_wd;
  logic [nrp_pkg::TS_W-1:0]   child_rd_q, child_wd;
  logic                       rec_re, rec_we, child_re, child_we;
  logic [IDX_W-1:0]           rec_ra, rec_wa, child_ra, child_wa;

  logic                       accept;
  logic                       in_slot_ok;
  logic [IDX_W-1:0]           in_idx;
  logic                       out_free;
  nrp_pkg::status_e           status;
  nrp_pkg::out_item_t         result;

  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign in_slot_ok  = int'(in_i.data.slot) < SLOT_COUNT;
  assign in_idx      = IDX_W'(in_i.data.slot);
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    if (!started_q) begin
      status = nrp_pkg::ST_NOT_STARTED;
    end else if (!stopped_q) begin
      status = nrp_pkg::ST_RUNNING;
    end else begin
      status = nrp_pkg::ST_OK;
    end
  end

  always_comb begin
    result                = '0;
    result.read_slot      = slot_q;
    result.status         = status;
    if (status == nrp_pkg::ST_OK) begin
      result.total_time = stop_ts_q - start_ts_q;
      if (slot_ok_q) begin
        result.hit_count      = rec_rd_q.hits;
        result.inclusive_time = rec_rd_q.inclusive_sum;
        result.exclusive_time = rec_rd_q.inclusive_sum - child_rd_q;
        result.used           = (rec_rd_q.inclusive_sum != '0);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    current_d   = current_q;
    started_d   = started_q;
    stopped_d   = stopped_q;
    start_ts_d  = start_ts_q;
    stop_ts_d   = stop_ts_q;
    clr_d       = clr_q;
    elapsed_d   = elapsed_q;
    par_idx_d   = par_idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    rec_re      = 1'b0;
    rec_ra      = in_idx;
    rec_we      = 1'b0;
    rec_wa      = idx_q;
    rec_wd      = rec_rd_q;
    child_re    = 1'b0;
    child_ra    = in_idx;
    child_we    = 1'b0;
    child_wa    = par_idx_q;
    child_wd    = child_rd_q + elapsed_q;

    case (state_q)
      S_CLEAR: begin
        rec_we   = 1'b1;
        rec_wa   = clr_q;
        rec_wd   = '0;
        child_we = 1'b1;
        child_wa = clr_q;
        child_wd = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_i.data.mode)
            nrp_pkg::MODE_BEGIN, nrp_pkg::MODE_END: begin
              if (in_slot_ok) begin
                rec_re  = 1'b1;
                state_d = S_LOOKUP;
              end
            end
            nrp_pkg::MODE_READ: begin
              rec_re   = in_slot_ok;
              child_re = in_slot_ok;
              state_d  = S_LOOKUP;
            end
            nrp_pkg::MODE_START: begin
              start_ts_d = in_i.data.timestamp;
              started_d  = 1'b1;
              stopped_d  = 1'b0;
            end
            nrp_pkg::MODE_STOP: begin
              stop_ts_d = in_i.data.timestamp;
              stopped_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_LOOKUP: begin
        case (mode_q)
          nrp_pkg::MODE_BEGIN: begin
            rec_we             = 1'b1;
            rec_wd.begin_stamp = ts_q;
            rec_wd.parent      = current_q;
            if (rec_rd_q.hits != '1) begin
              rec_wd.hits = rec_rd_q.hits + 1'b1;
            end
            current_d = slot_q;
            state_d   = S_IDLE;
          end
          nrp_pkg::MODE_END: begin
            // slot entry is written back in S_CHILD together with the parent
            elapsed_d = ts_q - rec_rd_q.begin_stamp;
            par_idx_d = IDX_W'(rec_rd_q.parent);
            child_re  = 1'b1;
            child_ra  = IDX_W'(rec_rd_q.parent);
            current_d = rec_rd_q.parent;
            state_d   = S_CHILD;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_CHILD: begin
        rec_we               = 1'b1;
        rec_wd.begin_stamp   = ts_q;
        rec_wd.inclusive_sum = rec_rd_q.inclusive_sum + elapsed_q;
        child_we             = 1'b1;
        state_d              = S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = result;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (rec_re) begin
      rec_rd_q <= rec_mem[rec_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    if (child_re) begin
      child_rd_q <= child_mem[child_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= in_i.data.mode;
      slot_q    <= in_i.data.slot;
      ts_q      <= in_i.data.timestamp;
      idx_q     <= in_idx;
      slot_ok_q <= in_slot_ok;
    end
    elapsed_q <= elapsed_d;
    par_idx_q <= par_idx_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      current_q   <= '0;
      started_q   <= 1'b0;
      stopped_q   <= 1'b0;
      start_ts_q  <= '0;
      stop_ts_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      current_q   <= current_d;
      started_q   <= started_d;
      stopped_q   <= stopped_d;
      start_ts_q  <= start_ts_d;
      stop_ts_q   <= stop_ts_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/nrp_checker.sv
`include "nested_region_profiler_unit_defines.svh"

module nrp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [nrp_pkg::MODE_W-1:0] in_mode_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input nrp_pkg::out_item_t         out_data_i
);

  // block is busy clearing its memories right after reset
  `NRP_ASSERT_ALWAYS(a_busy_after_reset, !rst_ni |=> !in_ready_i, "ready during clear")

  `NRP_ASSERT(a_read_busy,
              in_valid_i && in_ready_i && in_mode_i == nrp_pkg::MODE_READ |=> !in_ready_i,
              "read transfer did not stall the input")

  `NRP_ASSERT(a_stats_zero_unless_ok,
              out_valid_i && out_data_i.status != nrp_pkg::ST_OK |->
                out_data_i.hit_count == '0 && out_data_i.inclusive_time == '0 &&
                out_data_i.exclusive_time == '0 && out_data_i.total_time == '0 &&
                !out_data_i.used,
              "statistics reported while profile not complete")

  `NRP_ASSERT(a_used_flag,
              out_valid_i |-> out_data_i.used == (out_data_i.inclusive_time != '0),
              "used flag disagrees with inclusive time")

  `NRP_ASSERT(a_out_hold,
              out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i),
              "stalled result changed")

endmodule

bind nested_region_profiler_unit nrp_checker u_nrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.data.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// File: test/tb_nested_region_profiler_unit.sv
`timescale 1ns / 1ps

module tb_nested_region_profiler_unit;

  localparam int NUM_SLOTS    = 128;
  localparam int ITEMS_PHASE  = 550;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #10 clk_i = ~clk_i;

  nrp_stream_if #(.T(nrp_pkg::in_item_t))  in_if ();
  nrp_stream_if #(.T(nrp_pkg::out_item_t)) out_if ();

  nested_region_profiler_unit #(
    .SLOT_COUNT(NUM_SLOTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow of the profiler state
  logic [nrp_pkg::TS_W-1:0]   stamp_mem  [NUM_SLOTS];
  logic [nrp_pkg::HIT_W-1:0]  hit_mem    [NUM_SLOTS];
  logic [nrp_pkg::TS_W-1:0]   incl_mem   [NUM_SLOTS];
  logic [nrp_pkg::TS_W-1:0]   child_mem  [NUM_SLOTS];
  logic [nrp_pkg::SLOT_W-1:0] parent_mem [NUM_SLOTS];
  logic [nrp_pkg::SLOT_W-1:0] cur_slot;
  logic [nrp_pkg::TS_W-1:0]   prof_start_ts;
  logic [nrp_pkg::TS_W-1:0]   prof_stop_ts;
  logic                       prof_started;
  logic                       prof_stopped;

  nrp_pkg::in_item_t  event_q[$];
  nrp_pkg::out_item_t read_exp_q[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int mismatch_cnt;
  int cycle_cnt;
  int events_applied;
  int reads_checked;
  int reads_done_ok;
  logic in_taken;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  task automatic apply_event(input nrp_pkg::in_item_t ev);
    logic [nrp_pkg::SLOT_W-1:0] s;
    logic [nrp_pkg::SLOT_W-1:0] par;
    logic [nrp_pkg::TS_W-1:0]   elapsed;
    nrp_pkg::out_item_t         r;
    s = ev.slot;
    events_applied++;
    // every 7-bit slot lies inside the 128-entry table
    case (ev.mode)
      nrp_pkg::MODE_BEGIN: begin
        stamp_mem[s] = ev.timestamp;
        if (hit_mem[s] != '1) hit_mem[s] = hit_mem[s] + 1'b1;
        parent_mem[s] = cur_slot;
        cur_slot = s;
      end
      nrp_pkg::MODE_END: begin
        elapsed = ev.timestamp - stamp_mem[s];
        par = parent_mem[s];
        stamp_mem[s] = ev.timestamp;
        incl_mem[s] = incl_mem[s] + elapsed;
        cur_slot = par;
        child_mem[par] = child_mem[par] + elapsed;
      end
      nrp_pkg::MODE_START: begin
        prof_start_ts = ev.timestamp;
        prof_started = 1'b1;
        prof_stopped = 1'b0;
      end
      nrp_pkg::MODE_STOP: begin
        prof_stop_ts = ev.timestamp;
        prof_stopped = 1'b1;
      end
      nrp_pkg::MODE_READ: begin
        r = '0;
        r.read_slot = s;
        if (!prof_started) r.status = nrp_pkg::ST_NOT_STARTED;
        else if (!prof_stopped) r.status = nrp_pkg::ST_RUNNING;
        else r.status = nrp_pkg::ST_OK;
        if (r.status == nrp_pkg::ST_OK) begin
          r.total_time     = prof_stop_ts - prof_start_ts;
          r.hit_count      = hit_mem[s];
          r.inclusive_time = incl_mem[s];
          r.exclusive_time = incl_mem[s] - child_mem[s];
          r.used           = (incl_mem[s] != '0);
        end
        read_exp_q.push_back(r);
      end
      default: ;  // unused modes are dropped
    endcase
  endtask

  task automatic check_read_result(input nrp_pkg::out_item_t got);
    nrp_pkg::out_item_t want;
    if (read_exp_q.size() == 0) begin
      report_mismatch("unexpected result, read_slot", 64'(got.read_slot), 64'd0);
    end else begin
      want = read_exp_q.pop_front();
      reads_checked++;
      if (want.status == nrp_pkg::ST_OK) reads_done_ok++;
      if (got.read_slot !== want.read_slot)
        report_mismatch("read_slot", 64'(got.read_slot), 64'(want.read_slot));
      if (got.hit_count !== want.hit_count)
        report_mismatch("hit_count", 64'(got.hit_count), 64'(want.hit_count));
      if (got.inclusive_time !== want.inclusive_time)
        report_mismatch("inclusive_time", got.inclusive_time, want.inclusive_time);
      if (got.exclusive_time !== want.exclusive_time)
        report_mismatch("exclusive_time", got.exclusive_time, want.exclusive_time);
      if (got.total_time !== want.total_time)
        report_mismatch("total_time", got.total_time, want.total_time);
      if (got.used !== want.used)
        report_mismatch("used", 64'(got.used), 64'(want.used));
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
    end
  endtask

  // Monitor and predictor: everything sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (out_if.valid && out_if.ready) check_read_result(out_if.data);
      if (in_if.valid && in_if.ready) apply_event(in_if.data);
    end
    in_taken <= rst_ni && in_if.valid && in_if.ready;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               read_exp_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Event driver: valid holds until the transfer happens
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (event_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data  <= event_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_event(input int m, input int s,
                            input logic [nrp_pkg::TS_W-1:0] ts);
    nrp_pkg::in_item_t ev;
    ev.mode      = m[nrp_pkg::MODE_W-1:0];
    ev.slot      = s[nrp_pkg::SLOT_W-1:0];
    ev.timestamp = ts;
    event_q.push_back(ev);
  endtask

  function automatic int pick_slot();
    // mostly a small set so slots collect repeated hits
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, NUM_SLOTS - 1);
    return $urandom_range(0, 11);
  endfunction

  task automatic gen_directed();
    logic [nrp_pkg::TS_W-1:0] all_ones;
    all_ones = '1;
    push_event(nrp_pkg::MODE_READ, 0, 64'd0);            // not started yet
    push_event(nrp_pkg::MODE_STOP, 0, 64'd7);            // stop with no start
    push_event(nrp_pkg::MODE_READ, 127, all_ones);
    push_event(nrp_pkg::MODE_END, 90, 64'd1000);         // end with no begin
    push_event(nrp_pkg::MODE_BEGIN, 5, 64'd0);
    push_event(nrp_pkg::MODE_BEGIN, 127, all_ones);
    push_event(nrp_pkg::MODE_END, 127, 64'd10);          // elapsed wraps
    push_event(nrp_pkg::MODE_START, 0, all_ones);
    push_event(nrp_pkg::MODE_READ, 5, 64'd11);           // running
    push_event(nrp_pkg::MODE_READ + 1, 3, 64'd12);       // unused modes
    push_event(nrp_pkg::MODE_READ + 2, 3, 64'd13);
    push_event(nrp_pkg::MODE_READ + 3, 3, 64'd14);
    push_event(nrp_pkg::MODE_END, 5, 64'd20);
    push_event(nrp_pkg::MODE_STOP, 0, 64'd4);            // total wraps
    push_event(nrp_pkg::MODE_READ, 0, 64'd0);
    push_event(nrp_pkg::MODE_READ, 5, 64'd0);
    push_event(nrp_pkg::MODE_READ, 127, 64'd0);
    push_event(nrp_pkg::MODE_READ, 90, 64'd0);
    push_event(nrp_pkg::MODE_READ, 64, 64'd0);           // never touched
    push_event(nrp_pkg::MODE_START, 0, 64'd100);
    push_event(nrp_pkg::MODE_BEGIN, 0, 64'd100);
    push_event(nrp_pkg::MODE_END, 0, 64'd350);
    push_event(nrp_pkg::MODE_STOP, 0, 64'd400);
    push_event(nrp_pkg::MODE_READ, 0, 64'd0);
  endtask

  // One profiling run: start, nested begin/end pairs with occasional reads, stop, then reads
  task automatic gen_session();
    logic [nrp_pkg::TS_W-1:0] ts;
    int stk[$];
    int touched[$];
    int s;
    ts = ($urandom_range(0, 3) == 0) ? ('1 - 64'($urandom_range(0, 5000))) : rand64();
    push_event(nrp_pkg::MODE_START, $urandom_range(0, NUM_SLOTS - 1), ts);
    repeat ($urandom_range(6, 30)) begin
      ts += $urandom_range(1, 500);
      if (stk.size() != 0 && ($urandom_range(0, 1) == 1 || stk.size() >= 6)) begin
        push_event(nrp_pkg::MODE_END, stk.pop_back(), ts);
      end else if ($urandom_range(0, 9) == 0) begin
        push_event(nrp_pkg::MODE_READ, pick_slot(), rand64());
      end else begin
        s = pick_slot();
        stk.push_back(s);
        touched.push_back(s);
        push_event(nrp_pkg::MODE_BEGIN, s, ts);
      end
    end
    while (stk.size() != 0) begin
      ts += $urandom_range(1, 500);
      push_event(nrp_pkg::MODE_END, stk.pop_back(), ts);
    end
    push_event(nrp_pkg::MODE_STOP, $urandom_range(0, NUM_SLOTS - 1),
               ts + $urandom_range(0, 50));
    repeat ($urandom_range(2, 6)) begin
      if (touched.size() != 0 && $urandom_range(0, 3) != 0)
        s = touched[$urandom_range(0, touched.size() - 1)];
      else
        s = $urandom_range(0, NUM_SLOTS - 1);
      push_event(nrp_pkg::MODE_READ, s, rand64());
    end
  endtask

  task automatic gen_random(input int n_items);
    int target;
    target = event_q.size() + n_items;
    while (event_q.size() < target) begin
      if ($urandom_range(0, 4) != 0) begin
        gen_session();
      end else begin
        repeat ($urandom_range(1, 6))
          push_event(nrp_pkg::MODE_BEGIN + $urandom_range(0, 7),
                     $urandom_range(0, NUM_SLOTS - 1), rand64());
      end
    end
  endtask

  task automatic wait_idle();
    while (event_q.size() != 0 || in_if.valid || read_exp_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    in_taken     = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    events_applied = 0;
    reads_checked  = 0;
    reads_done_ok  = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      stamp_mem[i]  = '0;
      hit_mem[i]    = '0;
      incl_mem[i]   = '0;
      child_mem[i]  = '0;
      parent_mem[i] = '0;
    end
    cur_slot      = '0;
    prof_start_ts = '0;
    prof_stop_ts  = '0;
    prof_started  = 1'b0;
    prof_stopped  = 1'b0;

    tx_idle_pct = 10;
    rx_idle_pct = 81;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    gen_directed();
    gen_random(ITEMS_PHASE);
    wait_idle();

    tx_idle_pct = 81;
    rx_idle_pct = 10;
    gen_random(ITEMS_PHASE);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    gen_random(ITEMS_PHASE);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d events (nested regions, profile start/stop, unused modes) in %0d cycles",
             events_applied, cycle_cnt);
    $display("Checked %0d slot reads, %0d of them on a finished profile",
             reads_checked, reads_done_ok);
    if (mismatch_cnt == 0 && read_exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/nrp_pkg.sv
design/nrp_stream_if.sv
design/nested_region_profiler_unit.sv
design/nrp_checker.sv
test/tb_nested_region_profiler_unit.sv
